>>> sv/ddpr_pkg.sv
`default_nettype none

package ddpr_pkg;

  // Request codes carried by req_type.
  localparam int unsigned ReqW = 3;

  typedef enum logic [ReqW-1:0] {
    REQ_TICK    = 3'd0,
    REQ_COMMAND = 3'd1,
    REQ_RETRY   = 3'd2,
    REQ_STOP    = 3'd3,
    REQ_STOPNOW = 3'd4
  } req_e;

  // Field widths of the item and the result.
  localparam int unsigned TurnW    = 8;
  localparam int unsigned SpeedW   = 7;
  localparam int unsigned MeasW    = 8;
  localparam int unsigned TgtW     = 7;
  localparam int unsigned HoldW    = 4;
  localparam int unsigned BaseW    = 9;
  localparam int unsigned XW       = 15;

  // Configuration register indexes (word addresses).
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PWM_MIN  = 3'd0,
    CFG_PWM_STOP = 3'd1,
    CFG_PWM_MAX  = 3'd2,
    CFG_HOLDOFF  = 3'd3,
    CFG_BYPASS   = 3'd4
  } cfg_e;

  // Reset values of the configuration registers.
  localparam int unsigned PwmMinReset  = 230;
  localparam int unsigned PwmStopReset = 345;
  localparam int unsigned PwmMaxReset  = 460;
  localparam logic [HoldW-1:0] HoldoffReset = 4'd3;

  // Arithmetic constants of the target computation.
  localparam logic signed [BaseW-1:0] FullBase = 9'sd40;
  localparam logic signed [XW-1:0]    RoundAdd = 15'sd20;
  localparam logic [7:0]              Recip5   = 8'd205;
  localparam logic [7:0]              QuotPosMax = 8'd63;
  localparam logic [7:0]              QuotNegMax = 8'd64;
  localparam logic signed [TgtW-1:0]  TgtMax = {1'b0, {(TgtW-1){1'b1}}};
  localparam logic signed [TgtW-1:0]  TgtMin = {1'b1, {(TgtW-1){1'b0}}};

  // Divide by 40 truncating toward zero, then saturate to the target range.
  // The magnitude stays below 8192, so n/40 = (n/8)/5 and the divide by 5
  // is exact as a multiply by 205 and a shift by 10 for values below 1024.
  function automatic logic signed [TgtW-1:0] div40_sat(input logic signed [XW-1:0] x);
    logic [XW-1:0] n;
    logic [9:0]    m;
    logic [17:0]   p;
    logic [7:0]    q;
    logic signed [TgtW-1:0] r;
    n = x[XW-1] ? XW'(~x + 1'b1) : XW'(x);
    m = n[12:3];
    p = 18'(m) * 18'(Recip5);
    q = p[17:10];
    if (x[XW-1]) begin
      if (q > QuotNegMax) r = TgtMin;
      else                r = TgtW'(~q + 8'd1);
    end else begin
      if (q > QuotPosMax) r = TgtMax;
      else                r = TgtW'(q);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/differential_drive_pwm_ramp_unit.sv
`default_nettype none

// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_stall_o   req_type, turn/speed command,
//                                              measured speeds, gating flags
// out       output     out_valid_o/out_stall_i pwm_left/right, targets,
//                                              applied, still_pending
// cfg       input      psel/penable/pwrite     APB-style, pready always high
//
// Two register stages: the first forms base * speed + 20 for each wheel,
// the second divides by 40 and updates targets, PWM values and holdoffs.
// An item can be accepted every cycle while in_stall_o is low; its result is registered.
// Reset puts the PWM values at the stop value and clears targets and holdoffs.
// While a result is stalled, one more item can enter the first stage.

module differential_drive_pwm_ramp_unit #(
  parameter int unsigned PWM_BITS = 10
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,

  input  wire logic                                   in_valid_i,
  output      logic                                   in_stall_o,
  input  wire logic [ddpr_pkg::ReqW-1:0]              req_type_i,
  input  wire logic signed [ddpr_pkg::TurnW-1:0]      turn_cmd_i,
  input  wire logic signed [ddpr_pkg::SpeedW-1:0]     speed_cmd_i,
  input  wire logic signed [ddpr_pkg::MeasW-1:0]      measured_left_i,
  input  wire logic signed [ddpr_pkg::MeasW-1:0]      measured_right_i,
  input  wire logic                                   obstacle_seen_i,
  input  wire logic                                   halted_i,
  input  wire logic                                   override_on_i,

  output      logic                                   out_valid_o,
  input  wire logic                                   out_stall_i,
  output      logic [PWM_BITS-1:0]                    pwm_left_o,
  output      logic [PWM_BITS-1:0]                    pwm_right_o,
  output      logic signed [ddpr_pkg::TgtW-1:0]       target_left_out_o,
  output      logic signed [ddpr_pkg::TgtW-1:0]       target_right_out_o,
  output      logic                                   applied_o,
  output      logic                                   still_pending_o,

  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [ddpr_pkg::AddrW-1:0]             paddr,
  input  wire logic [ddpr_pkg::DataW-1:0]             pwdata,
  output      logic [ddpr_pkg::DataW-1:0]             prdata,
  output      logic                                   pready
);

  import ddpr_pkg::*;

  // Configuration registers.
  logic [PWM_BITS-1:0] pwm_min_q, pwm_stop_q, pwm_max_q;
  logic [HoldW-1:0]    holdoff_q;
  logic                bypass_q;
  logic                cfg_wr;
  cfg_e                cfg_idx;

  // First stage.
  logic                      a_valid_q;
  req_e                      a_req_q;
  logic signed [XW-1:0]      a_xl_q, a_xr_q;
  logic signed [MeasW-1:0]   a_meas_l_q, a_meas_r_q;
  logic                      a_obst_q, a_halt_q, a_ovr_q;
  logic                      a_load;

  // First stage arithmetic.
  logic [TurnW-1:0]          mag;
  logic signed [BaseW-1:0]   inner, base_l, base_r;
  logic signed [XW-1:0]      prod_l, prod_r;

  // Second stage state and result.
  logic [PWM_BITS-1:0]       pwm_l_q, pwm_r_q, pwm_l_d, pwm_r_d;
  logic [HoldW-1:0]          hold_l_q, hold_r_q, hold_l_d, hold_r_d;
  logic signed [TgtW-1:0]    tgt_l_q, tgt_r_q, tgt_l_d, tgt_r_d;
  logic                      pend_q, pend_d;
  logic signed [TgtW-1:0]    pend_l_q, pend_r_q, pend_l_d, pend_r_d;
  logic                      applied_q, applied_d;
  logic                      out_valid_q;
  logic                      b_adv;

  // Second stage working values.
  logic signed [TgtW-1:0]    new_l, new_r, src_l, src_r;
  logic                      gate_open, have_req;

  // Configuration port: writes in the access phase, reads are combinational.
  assign pready  = 1'b1;
  assign cfg_idx = cfg_e'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_min_q  <= PWM_BITS'(PwmMinReset);
      pwm_stop_q <= PWM_BITS'(PwmStopReset);
      pwm_max_q  <= PWM_BITS'(PwmMaxReset);
      holdoff_q  <= HoldoffReset;
      bypass_q   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        CFG_PWM_MIN:  pwm_min_q  <= pwdata[PWM_BITS-1:0];
        CFG_PWM_STOP: pwm_stop_q <= pwdata[PWM_BITS-1:0];
        CFG_PWM_MAX:  pwm_max_q  <= pwdata[PWM_BITS-1:0];
        CFG_HOLDOFF:  holdoff_q  <= pwdata[HoldW-1:0];
        CFG_BYPASS:   bypass_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      CFG_PWM_MIN:  prdata = DataW'(pwm_min_q);
      CFG_PWM_STOP: prdata = DataW'(pwm_stop_q);
      CFG_PWM_MAX:  prdata = DataW'(pwm_max_q);
      CFG_HOLDOFF:  prdata = DataW'(holdoff_q);
      CFG_BYPASS:   prdata = DataW'(bypass_q);
      default:      prdata = '0;
    endcase
  end

  // Flow control: the second stage moves when its result slot is free or taken.
  assign b_adv      = !out_valid_q || !out_stall_i;
  assign a_load     = !a_valid_q || b_adv;
  assign in_stall_o = !a_load;

  // Wheel bases from the incoming turn; the right wheel is inner for turn >= 0.
  always_comb begin
    mag    = turn_cmd_i[TurnW-1] ? TurnW'(~turn_cmd_i + 1'b1) : TurnW'(turn_cmd_i);
    inner  = FullBase - signed'({1'b0, mag});
    base_l = turn_cmd_i[TurnW-1] ? inner : FullBase;
    base_r = turn_cmd_i[TurnW-1] ? FullBase : inner;
    prod_l = XW'(base_l) * XW'(speed_cmd_i);
    prod_r = XW'(base_r) * XW'(speed_cmd_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_load) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load && in_valid_i) begin
      a_req_q    <= req_e'(req_type_i);
      a_xl_q     <= prod_l + RoundAdd;
      a_xr_q     <= prod_r + RoundAdd;
      a_meas_l_q <= measured_left_i;
      a_meas_r_q <= measured_right_i;
      a_obst_q   <= obstacle_seen_i;
      a_halt_q   <= halted_i;
      a_ovr_q    <= override_on_i;
    end
  end

  // Second stage: divide, gate the request, ramp the PWM values.
  always_comb begin
    new_l     = div40_sat(a_xl_q);
    new_r     = div40_sat(a_xr_q);
    gate_open = !a_halt_q && !(a_obst_q && !bypass_q && !a_ovr_q);

    pwm_l_d   = pwm_l_q;
    pwm_r_d   = pwm_r_q;
    hold_l_d  = hold_l_q;
    hold_r_d  = hold_r_q;
    tgt_l_d   = tgt_l_q;
    tgt_r_d   = tgt_r_q;
    pend_d    = pend_q;
    pend_l_d  = pend_l_q;
    pend_r_d  = pend_r_q;
    applied_d = 1'b0;
    have_req  = 1'b0;
    src_l     = pend_l_q;
    src_r     = pend_r_q;

    case (a_req_q)
      REQ_COMMAND: begin
        pend_l_d = new_l;
        pend_r_d = new_r;
        pend_d   = 1'b1;
        src_l    = new_l;
        src_r    = new_r;
        have_req = 1'b1;
      end
      REQ_RETRY: begin
        have_req = pend_q;
      end
      REQ_TICK: begin
        // Left wheel ramp.
        if (hold_l_q != '0) begin
          hold_l_d = hold_l_q - HoldW'(1);
        end else if (MeasW'(tgt_l_q) > a_meas_l_q) begin
          if (pwm_l_q < pwm_max_q) pwm_l_d = pwm_l_q + PWM_BITS'(1);
          hold_l_d = holdoff_q;
        end else if (MeasW'(tgt_l_q) < a_meas_l_q) begin
          if (pwm_l_q > pwm_min_q) pwm_l_d = pwm_l_q - PWM_BITS'(1);
          hold_l_d = holdoff_q;
        end
        // Right wheel ramp.
        if (hold_r_q != '0) begin
          hold_r_d = hold_r_q - HoldW'(1);
        end else if (MeasW'(tgt_r_q) > a_meas_r_q) begin
          if (pwm_r_q < pwm_max_q) pwm_r_d = pwm_r_q + PWM_BITS'(1);
          hold_r_d = holdoff_q;
        end else if (MeasW'(tgt_r_q) < a_meas_r_q) begin
          if (pwm_r_q > pwm_min_q) pwm_r_d = pwm_r_q - PWM_BITS'(1);
          hold_r_d = holdoff_q;
        end
      end
      REQ_STOP: begin
        tgt_l_d = '0;
        tgt_r_d = '0;
      end
      REQ_STOPNOW: begin
        tgt_l_d = '0;
        tgt_r_d = '0;
        pwm_l_d = pwm_stop_q;
        pwm_r_d = pwm_stop_q;
      end
      default: ;
    endcase

    // Apply a waiting request once the gate is open.
    if (have_req && gate_open) begin
      tgt_l_d   = src_l;
      tgt_r_d   = src_r;
      pend_d    = 1'b0;
      applied_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_l_q     <= PWM_BITS'(PwmStopReset);
      pwm_r_q     <= PWM_BITS'(PwmStopReset);
      hold_l_q    <= '0;
      hold_r_q    <= '0;
      tgt_l_q     <= '0;
      tgt_r_q     <= '0;
      pend_q      <= 1'b0;
      pend_l_q    <= '0;
      pend_r_q    <= '0;
      applied_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (b_adv) begin
      out_valid_q <= a_valid_q;
      if (a_valid_q) begin
        pwm_l_q   <= pwm_l_d;
        pwm_r_q   <= pwm_r_d;
        hold_l_q  <= hold_l_d;
        hold_r_q  <= hold_r_d;
        tgt_l_q   <= tgt_l_d;
        tgt_r_q   <= tgt_r_d;
        pend_q    <= pend_d;
        pend_l_q  <= pend_l_d;
        pend_r_q  <= pend_r_d;
        applied_q <= applied_d;
      end
    end
  end

  // The state only changes when the result slot is free or its result is taken, so it is the result.
  assign out_valid_o        = out_valid_q;
  assign pwm_left_o         = pwm_l_q;
  assign pwm_right_o        = pwm_r_q;
  assign target_left_out_o  = tgt_l_q;
  assign target_right_out_o = tgt_r_q;
  assign applied_o          = applied_q;
  assign still_pending_o    = pend_q;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none

module tb_top;
  import ddpr_pkg::*;

  // Arithmetic of the wheel target: base * speed + bias, divided by the full base.
  localparam int WheelBase  = 40;
  localparam int RoundBias  = 20;
  localparam int HoldCycles = 120;

  typedef struct packed {
    logic [9:0]      pwm_left;
    logic [9:0]      pwm_right;
    logic [TgtW-1:0] target_left;
    logic [TgtW-1:0] target_right;
    logic            applied;
    logic            still_pending;
  } drive_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [ReqW-1:0]          req_type_i;
  logic signed [TurnW-1:0]  turn_cmd_i;
  logic signed [SpeedW-1:0] speed_cmd_i;
  logic signed [MeasW-1:0]  measured_left_i;
  logic signed [MeasW-1:0]  measured_right_i;
  logic                     obstacle_seen_i;
  logic                     halted_i;
  logic                     override_on_i;

  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [9:0]               pwm_left_o;
  logic [9:0]               pwm_right_o;
  logic signed [TgtW-1:0]   target_left_out_o;
  logic signed [TgtW-1:0]   target_right_out_o;
  logic                     applied_o;
  logic                     still_pending_o;

  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [AddrW-1:0]         paddr;
  logic [DataW-1:0]         pwdata;
  logic [DataW-1:0]         prdata;
  logic                     pready;

  // Predicted state of the controller and its register copy.
  logic [9:0]  lim_min, lim_stop, lim_max;
  logic [3:0]  lim_holdoff;
  logic        lim_bypass;
  logic [9:0]  pwm_l, pwm_r;
  logic [3:0]  hold_l, hold_r;
  int          tgt_l, tgt_r;
  logic        cmd_waiting;
  int          cmd_turn, cmd_speed;

  drive_result_t expected_wheel_q[$];
  int          errors;
  int          items_accepted;
  int          results_checked;
  int          settings_used;
  int          gap_pct;
  int          stall_pct;
  bit          hold_req;

  differential_drive_pwm_ramp_unit u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .req_type_i         (req_type_i),
    .turn_cmd_i         (turn_cmd_i),
    .speed_cmd_i        (speed_cmd_i),
    .measured_left_i    (measured_left_i),
    .measured_right_i   (measured_right_i),
    .obstacle_seen_i    (obstacle_seen_i),
    .halted_i           (halted_i),
    .override_on_i      (override_on_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .pwm_left_o         (pwm_left_o),
    .pwm_right_o        (pwm_right_o),
    .target_left_out_o  (target_left_out_o),
    .target_right_out_o (target_right_out_o),
    .applied_o          (applied_o),
    .still_pending_o    (still_pending_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Divide toward zero, then saturate to the 7-bit target range.
  function automatic int scaled_target(input int base, input int spd);
    int q;
    q = (base * spd + RoundBias) / WheelBase;
    if (q > 63) q = 63;
    if (q < -64) q = -64;
    return q;
  endfunction

  // One wheel on a tick: count down the holdoff, or step the PWM toward the target.
  task automatic ramp_wheel(inout logic [9:0] pwm, inout logic [3:0] hold,
                            input int tgt, input int meas);
    if (hold != 4'd0) begin
      hold = hold - 4'd1;
    end else if (tgt > meas) begin
      if (pwm < lim_max) pwm = pwm + 10'd1;
      hold = lim_holdoff;
    end else if (tgt < meas) begin
      if (pwm > lim_min) pwm = pwm - 10'd1;
      hold = lim_holdoff;
    end
  endtask

  // Advance the predicted controller by one item and form its result.
  task automatic predict_drive_step(input logic [2:0] req, input logic signed [7:0] turn,
                                    input logic signed [6:0] spd,
                                    input logic signed [7:0] meas_l,
                                    input logic signed [7:0] meas_r,
                                    input logic obst, input logic halt, input logic ovr,
                                    output drive_result_t res);
    logic gate_open;
    logic applied;
    int   mag, base_l, base_r;
    gate_open = !halt && !(obst && !lim_bypass && !ovr);
    applied = 1'b0;
    if (req == REQ_COMMAND) begin
      cmd_turn = int'(turn);
      cmd_speed = int'(spd);
      cmd_waiting = 1'b1;
    end
    if ((req == REQ_COMMAND || req == REQ_RETRY) && cmd_waiting && gate_open) begin
      // The right wheel is the inner one for straight or right turns.
      mag = (cmd_turn < 0) ? -cmd_turn : cmd_turn;
      base_l = (cmd_turn >= 0) ? WheelBase : WheelBase - mag;
      base_r = (cmd_turn >= 0) ? WheelBase - mag : WheelBase;
      tgt_l = scaled_target(base_l, cmd_speed);
      tgt_r = scaled_target(base_r, cmd_speed);
      cmd_waiting = 1'b0;
      applied = 1'b1;
    end
    if (req == REQ_TICK) begin
      ramp_wheel(pwm_l, hold_l, tgt_l, int'(meas_l));
      ramp_wheel(pwm_r, hold_r, tgt_r, int'(meas_r));
    end
    if (req == REQ_STOP || req == REQ_STOPNOW) begin
      tgt_l = 0;
      tgt_r = 0;
    end
    if (req == REQ_STOPNOW) begin
      pwm_l = lim_stop;
      pwm_r = lim_stop;
    end
    res.pwm_left = pwm_l;
    res.pwm_right = pwm_r;
    res.target_left = tgt_l[TgtW-1:0];
    res.target_right = tgt_r[TgtW-1:0];
    res.applied = applied;
    res.still_pending = cmd_waiting;
  endtask

  task automatic report_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  // Check each result against the oldest prediction, then predict the item taken this edge.
  always @(posedge clk_i) begin : scoreboard
    drive_result_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_wheel_q.size() == 0) begin
          $display("%0t: result arrived with nothing expected, pwm %0d/%0d", $time,
                   pwm_left_o, pwm_right_o);
          errors++;
        end else begin
          exp_r = expected_wheel_q.pop_front();
          results_checked++;
          report_field("pwm_left", int'(exp_r.pwm_left), int'(pwm_left_o));
          report_field("pwm_right", int'(exp_r.pwm_right), int'(pwm_right_o));
          report_field("target_left", int'($signed(exp_r.target_left)),
                       int'(target_left_out_o));
          report_field("target_right", int'($signed(exp_r.target_right)),
                       int'(target_right_out_o));
          report_field("applied", int'(exp_r.applied), int'(applied_o));
          report_field("still_pending", int'(exp_r.still_pending), int'(still_pending_o));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        predict_drive_step(req_type_i, turn_cmd_i, speed_cmd_i, measured_left_i,
                           measured_right_i, obstacle_seen_i, halted_i, override_on_i, exp_r);
        expected_wheel_q.push_back(exp_r);
        items_accepted++;
      end
    end
  end

  // Output stall: random bursts, or one long hold-off on request.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offer one item, sometimes after a random gap, and hold it until it is taken.
  task automatic send_item(input logic [2:0] req, input logic signed [7:0] turn,
                           input logic signed [6:0] spd, input logic signed [7:0] meas_l,
                           input logic signed [7:0] meas_r, input logic obst,
                           input logic halt, input logic ovr);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    req_type_i       <= req;
    turn_cmd_i       <= turn;
    speed_cmd_i      <= spd;
    measured_left_i  <= meas_l;
    measured_right_i <= meas_r;
    obstacle_seen_i  <= obst;
    halted_i         <= halt;
    override_on_i    <= ovr;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Mostly ticks and in-range commands; a few out-of-range values and unknown codes.
  task automatic send_random_item();
    int          r, t;
    logic [2:0]  req;
    logic [7:0]  turn, ml, mr;
    logic [6:0]  spd;
    r = $urandom_range(0, 99);
    if (r < 50)      req = REQ_TICK;
    else if (r < 68) req = REQ_COMMAND;
    else if (r < 78) req = REQ_RETRY;
    else if (r < 86) req = REQ_STOP;
    else if (r < 93) req = REQ_STOPNOW;
    else             req = 3'($urandom_range(REQ_STOPNOW + 1, 7));
    t = int'($urandom_range(0, 160)) - 80;
    turn = ($urandom_range(0, 99) < 85) ? t[7:0] : 8'($urandom);
    t = int'($urandom_range(0, 100)) - 50;
    spd = ($urandom_range(0, 99) < 85) ? t[6:0] : 7'($urandom);
    // Measured speeds near the current targets let the ramp settle and reverse.
    t = tgt_l + int'($urandom_range(0, 6)) - 3;
    ml = $urandom_range(0, 1) ? t[7:0] : 8'($urandom);
    t = tgt_r + int'($urandom_range(0, 6)) - 3;
    mr = $urandom_range(0, 1) ? t[7:0] : 8'($urandom);
    send_item(req, turn, spd, ml, mr, $urandom_range(0, 3) == 0,
              $urandom_range(0, 5) == 0, $urandom_range(0, 3) == 0);
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (expected_wheel_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic cfg_write(input cfg_e idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      CFG_PWM_MIN:  lim_min = value[9:0];
      CFG_PWM_STOP: lim_stop = value[9:0];
      CFG_PWM_MAX:  lim_max = value[9:0];
      CFG_HOLDOFF:  lim_holdoff = value[3:0];
      CFG_BYPASS:   lim_bypass = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_limits(input int mn, input int st, input int mx, input int hold,
                              input int byp);
    wait_results_drained();
    cfg_write(CFG_PWM_MIN, mn);
    cfg_write(CFG_PWM_STOP, st);
    cfg_write(CFG_PWM_MAX, mx);
    cfg_write(CFG_HOLDOFF, hold);
    cfg_write(CFG_BYPASS, byp);
    settings_used++;
  endtask

  // Reset defaults: gating, saturation of targets, stops and unknown codes.
  task automatic test_directed_cases();
    send_item(REQ_COMMAND, 8'sd0, 7'sd50, 8'sd0, 8'sd0, 1'b0, 1'b0, 1'b0);
    send_item(REQ_TICK, 8'sd0, 7'sd0, -8'sd128, 8'sd127, 1'b0, 1'b0, 1'b0);
    send_item(REQ_TICK, 8'sd0, 7'sd0, 8'sd0, 8'sd0, 1'b0, 1'b0, 1'b0);
    // A seen obstacle blocks the command until override is on.
    send_item(REQ_COMMAND, 8'sd80, -7'sd50, 8'sd0, 8'sd0, 1'b1, 1'b0, 1'b0);
    send_item(REQ_RETRY, 8'sd0, 7'sd0, 8'sd0, 8'sd0, 1'b1, 1'b0, 1'b1);
    // Retry with nothing waiting changes nothing.
    send_item(REQ_RETRY, 8'sd0, 7'sd0, 8'sd0, 8'sd0, 1'b0, 1'b0, 1'b0);
    // Halt blocks even with override; a stop keeps the waiting command.
    send_item(REQ_COMMAND, -8'sd80, 7'sd50, 8'sd0, 8'sd0, 1'b0, 1'b1, 1'b1);
    send_item(REQ_STOP, 8'sd0, 7'sd0, 8'sd0, 8'sd0, 1'b0, 1'b0, 1'b0);
    send_item(REQ_RETRY, 8'sd0, 7'sd0, 8'sd0, 8'sd0, 1'b0, 1'b1, 1'b0);
    send_item(REQ_RETRY, 8'sd0, 7'sd0, 8'sd0, 8'sd0, 1'b0, 1'b0, 1'b0);
    // Out-of-range turns saturate the inner wheel's target; a turn of 40 zeroes it.
    send_item(REQ_COMMAND, 8'sd127, 7'sd63, 8'sd0, 8'sd0, 1'b0, 1'b0, 1'b0);
    send_item(REQ_COMMAND, -8'sd128, -7'sd64, 8'sd0, 8'sd0, 1'b0, 1'b0, 1'b0);
    send_item(REQ_COMMAND, 8'sd40, -7'sd64, 8'sd0, 8'sd0, 1'b0, 1'b0, 1'b0);
    send_item(REQ_TICK, 8'sd0, 7'sd0, 8'sd127, -8'sd128, 1'b0, 1'b0, 1'b0);
    // Equal target and measured speed holds the PWM value; the holdoff counts down to zero and is not reloaded.
    send_item(REQ_TICK, 8'sd0, 7'sd0, -8'sd63, 8'sd0, 1'b0, 1'b0, 1'b0);
    send_item(REQ_TICK, 8'sd0, 7'sd0, -8'sd63, 8'sd0, 1'b0, 1'b0, 1'b0);
    send_item(REQ_TICK, 8'sd0, 7'sd0, -8'sd63, 8'sd0, 1'b0, 1'b0, 1'b0);
    send_item(REQ_TICK, 8'sd0, 7'sd0, -8'sd63, 8'sd0, 1'b0, 1'b0, 1'b0);
    send_item(REQ_STOPNOW, -8'sd1, -7'sd1, -8'sd1, -8'sd1, 1'b1, 1'b1, 1'b1);
    for (int c = REQ_STOPNOW + 1; c < 8; c++) begin
      send_item(3'(c), -8'sd1, -7'sd1, -8'sd1, -8'sd1, 1'b1, 1'b1, 1'b1);
    end
    send_item(REQ_COMMAND, -8'sd1, 7'sd1, 8'sd0, 8'sd0, 1'b1, 1'b0, 1'b0);
  endtask

  // Sweep of limit settings, including limits that the stop value lies outside.
  task automatic test_limit_settings();
    int mn[7] = '{340, 0, 1023, 300, 500, 0, 200};
    int st[7] = '{345, 0, 1023, 600, 100, 512, 345};
    int mx[7] = '{350, 1023, 1023, 400, 700, 1023, 480};
    int hd[7] = '{0, 15, 1, 2, 0, 5, 1};
    int bp[7] = '{1, 0, 1, 0, 1, 0, 1};
    for (int s = 0; s < 7; s++) begin
      apply_limits(mn[s], st[s], mx[s], hd[s], bp[s]);
      send_item(REQ_STOPNOW, 8'sd0, 7'sd0, 8'sd0, 8'sd0, 1'b0, 1'b0, 1'b0);
      repeat (60) send_random_item();
    end
  endtask

  // Hold the output off while items keep coming, so the input must stall.
  task automatic test_output_holdoff();
    gap_pct = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    repeat (30) send_random_item();
  endtask

  task automatic test_random_traffic();
    apply_limits(210, 345, 470, 0, 0);
    gap_pct = 30;
    stall_pct = 30;
    repeat (300) send_random_item();
    gap_pct = 0;
    repeat (150) send_random_item();
    gap_pct = 25;
    stall_pct = 0;
    repeat (150) send_random_item();
    // Closing stretch at full rate on both sides.
    gap_pct = 0;
    repeat (150) send_random_item();
  endtask

  initial begin
    errors = 0;
    items_accepted = 0;
    results_checked = 0;
    settings_used = 1;
    gap_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    lim_min = 10'd230;
    lim_stop = 10'd345;
    lim_max = 10'd460;
    lim_holdoff = 4'd3;
    lim_bypass = 1'b0;
    pwm_l = 10'd345;
    pwm_r = 10'd345;
    hold_l = 4'd0;
    hold_r = 4'd0;
    tgt_l = 0;
    tgt_r = 0;
    cmd_waiting = 1'b0;
    cmd_turn = 0;
    cmd_speed = 0;
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    req_type_i       <= REQ_TICK;
    turn_cmd_i       <= '0;
    speed_cmd_i      <= '0;
    measured_left_i  <= '0;
    measured_right_i <= '0;
    obstacle_seen_i  <= 1'b0;
    halted_i         <= 1'b0;
    override_on_i    <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    gap_pct = 20;
    stall_pct = 20;
    test_limit_settings();
    test_output_holdoff();
    test_random_traffic();
    wait_results_drained();

    $display("Covered %0d items under %0d register settings, with a long output hold-off.",
             items_accepted, settings_used);
    $display("Compared %0d results field by field; %0d mismatches.", results_checked, errors);
    if (errors == 0 && expected_wheel_q.size() == 0) begin
      $display("differential_drive_pwm_ramp_unit test passed");
    end else begin
      $display("differential_drive_pwm_ramp_unit test failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Timeout with %0d results outstanding.", expected_wheel_q.size());
    $display("differential_drive_pwm_ramp_unit test failed");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
sv/ddpr_pkg.sv
sv/differential_drive_pwm_ramp_unit.sv
tb/tb_top.sv
